@@ hw/rtl/dctp_pkg.sv @@
`default_nettype none

package dctp_pkg;

    // pixels handled per convert item
    localparam int LANES = 8;

    localparam int S_DATA_W = 152;
    localparam int M_DATA_W = 40;

    // item kinds carried in s_tuser
    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    // 4x4 ordered dither ranks, cell = {y, x}
    localparam logic [3:0] BAYER_RANK [16] = '{
        4'd0,  4'd8,  4'd2,  4'd10,
        4'd12, 4'd4,  4'd14, 4'd6,
        4'd3,  4'd11, 4'd1,  4'd9,
        4'd15, 4'd7,  4'd13, 4'd5
    };

    // pipeline enables shared by all lanes
    typedef struct packed
    {
        logic rd_en;
        logic s2_en;
        logic s3_en;
    } lane_ctrl_t;

    // weight half-row write, broadcast to every lane copy
    typedef struct packed
    {
        logic        en;
        logic [7:0]  index;
        logic        half;
        logic [63:0] data;
    } lane_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/dctp_lane.sv @@
`default_nettype none

module dctp_lane #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int LANE            = 0
) (
    input  wire logic                clk,
    input  wire dctp_pkg::lane_ctrl_t ctrl,
    input  wire dctp_pkg::lane_wr_t   wr,
    input  wire logic [7:0]          pixel,
    input  wire logic [1:0]          x_phase,
    input  wire logic [1:0]          y_phase,
    output logic [3:0]               color
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [63:0] lo_mem [PALETTE_ENTRIES];
    logic [63:0] hi_mem [PALETTE_ENTRIES];

    logic        wr_ok;
    logic        rd_in_range;
    logic [3:0]  rank_sel;

    logic [63:0] lo_rd_reg;
    logic [63:0] hi_rd_reg;
    logic        oob_reg;
    logic [3:0]  rank1_reg;

    logic [10:0] lo_pref_next [8];
    logic [10:0] hi_pref_next [8];
    logic [10:0] lo_pref_reg  [8];
    logic [10:0] hi_pref_reg  [8];
    logic [3:0]  rank2_reg;

    logic [15:0] hit;
    logic [3:0]  color_next;
    logic [3:0]  color_reg;

    assign wr_ok       = wr.en && ({1'b0, wr.index} < 9'(PALETTE_ENTRIES));
    assign rd_in_range = {1'b0, pixel} < 9'(PALETTE_ENTRIES);
    assign rank_sel    = {y_phase, 2'(x_phase + 2'(LANE))};

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            if (wr.half)
                hi_mem[wr.index[AW-1:0]] <= wr.data;
            else
                lo_mem[wr.index[AW-1:0]] <= wr.data;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            oob_reg   <= !rd_in_range;
            rank1_reg <= dctp_pkg::BAYER_RANK[rank_sel];
            if (rd_in_range)
            begin
                lo_rd_reg <= lo_mem[pixel[AW-1:0]];
                hi_rd_reg <= hi_mem[pixel[AW-1:0]];
            end
        end
    end

    // running sums within each half, index out of range reads as all zero
    always_comb
    begin
        logic [10:0] lo_acc;
        logic [10:0] hi_acc;
        lo_acc = '0;
        hi_acc = '0;
        for (int j = 0; j < 8; j++)
        begin
            if (!oob_reg)
            begin
                lo_acc = lo_acc + 11'(lo_rd_reg[8*j +: 8]);
                hi_acc = hi_acc + 11'(hi_rd_reg[8*j +: 8]);
            end
            lo_pref_next[j] = lo_acc;
            hi_pref_next[j] = hi_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_en)
        begin
            lo_pref_reg <= lo_pref_next;
            hi_pref_reg <= hi_pref_next;
            rank2_reg   <= rank1_reg;
        end
    end

    // first color whose running sum passes the rank, else 15
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            hit[c]     = 12'(rank2_reg) < 12'(lo_pref_reg[c]);
            hit[c + 8] = 12'(rank2_reg) < (12'(lo_pref_reg[7]) + 12'(hi_pref_reg[c]));
        end
        color_next = 4'd15;
        for (int c = 15; c >= 0; c--)
        begin
            if (hit[c])
                color_next = 4'(c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s3_en)
            color_reg <= color_next;
    end

    assign color = color_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dithered_chunky_to_planar_core.sv @@
// a convert item's result passes the stage 1, stage 2 and stage 3 registers before it is shown
// throughput: one item per cycle, load or convert, unless a full pipeline waits on m_tready;
// each lane owns a copy of the weight ram so all eight pixels read their weights through one port each
// reset clears the pipeline valid flags only; the weight rams are not cleared
// and a weight row must be loaded before a convert looks it up
`default_nettype none

module dithered_chunky_to_planar_core #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // palette_index[7:0], half[8], weight_bits[72:9], pixels[136:73],
    // x_phase[138:137], y_phase[140:139], lane_valid[148:141], transparent[149]
    input  wire logic [dctp_pkg::S_DATA_W-1:0]   s_tdata,
    // operation[0]
    input  wire logic                            s_tuser,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // plane0[7:0], plane1[15:8], plane2[23:16], plane3[31:24], write_mask[39:32]
    output logic [dctp_pkg::M_DATA_W-1:0]        m_tdata
);

    // input fields
    logic [7:0]  palette_index;
    logic        half;
    logic [63:0] weight_bits;
    logic [63:0] pixels;
    logic [1:0]  x_phase;
    logic [1:0]  y_phase;
    logic [7:0]  lane_valid;
    logic        transparent;

    assign palette_index = s_tdata[7:0];
    assign half          = s_tdata[8];
    assign weight_bits   = s_tdata[72:9];
    assign pixels        = s_tdata[136:73];
    assign x_phase       = s_tdata[138:137];
    assign y_phase       = s_tdata[140:139];
    assign lane_valid    = s_tdata[148:141];
    assign transparent   = s_tdata[149];

    // handshake and stage control
    logic s_accept;
    logic accept_load;
    logic accept_convert;

    // stage 1 holds the ram read data, stage 2 the running sums, stage 3 the result
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic ready1, ready2, ready3;

    // a stage moves on when the one after it is empty or moving
    assign ready3   = !s3_valid_reg || m_tready;
    assign ready2   = !s2_valid_reg || ready3;
    assign ready1   = !s1_valid_reg || ready2;
    assign s_tready = ready1;

    assign s_accept       = s_tvalid && s_tready;
    assign accept_load    = s_accept && (s_tuser == dctp_pkg::OP_LOAD);
    assign accept_convert = s_accept && (s_tuser == dctp_pkg::OP_CONVERT);

    always_comb
    begin
        s1_valid_next = ready1 ? accept_convert : s1_valid_reg;
        s2_valid_next = ready2 ? s1_valid_reg   : s2_valid_reg;
        s3_valid_next = ready3 ? s2_valid_reg   : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // control and write bundles for the lanes
    dctp_pkg::lane_ctrl_t lane_ctrl;
    dctp_pkg::lane_wr_t   lane_wr;

    assign lane_ctrl.rd_en = accept_convert;
    assign lane_ctrl.s2_en = ready2;
    assign lane_ctrl.s3_en = ready3;

    // a load is written at its accept edge, so a convert right after sees it
    assign lane_wr.en    = accept_load;
    assign lane_wr.index = palette_index;
    assign lane_wr.half  = half;
    assign lane_wr.data  = weight_bits;

    // one lane per pixel, each with its own weight ram copy
    logic [3:0] lane_color [dctp_pkg::LANES];

    for (genvar k = 0; k < dctp_pkg::LANES; k++)
    begin : g_lane
        dctp_lane #(
            .PALETTE_ENTRIES (PALETTE_ENTRIES),
            .LANE            (k)
        ) u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .wr      (lane_wr),
            .pixel   (pixels[8*k +: 8]),
            .x_phase (x_phase),
            .y_phase (y_phase),
            .color   (lane_color[k])
        );
    end

    // write mask, pixel 0 at bit 7, index 0 dropped in transparent mode
    logic [7:0] mask_in;
    logic [7:0] mask1_reg;
    logic [7:0] mask2_reg;
    logic [7:0] mask3_reg;

    always_comb
    begin
        for (int k = 0; k < dctp_pkg::LANES; k++)
            mask_in[7 - k] = lane_valid[k] && !(transparent && (pixels[8*k +: 8] == 8'd0));
    end

    always_ff @(posedge clk)
    begin
        if (accept_convert)
            mask1_reg <= mask_in;
        if (ready2)
            mask2_reg <= mask1_reg;
        if (ready3)
            mask3_reg <= mask2_reg;
    end

    // planar packing of the stage 3 colors
    logic [7:0] plane [4];

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            for (int k = 0; k < dctp_pkg::LANES; k++)
                plane[p][7 - k] = lane_color[k][p];
        end
    end

    assign m_tvalid = s3_valid_reg;
    assign m_tdata  = {mask3_reg, plane[3], plane[2], plane[1], plane[0]};

    // checks on the pipeline control
    a_convert_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept_convert |=> s1_valid_reg)
        else $error("convert item did not enter stage 1");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_load |=> !s1_valid_reg)
        else $error("load item created a pipeline entry");

    a_stage2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg && !m_tready) |=> s2_valid_reg)
        else $error("stage 2 item lost during stall");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg))
        else $error("input stalled while the pipeline has a bubble");

endmodule

`default_nettype wire
